[hdl/mthw_pkg.sv]
// Shared constants and types of the multi-task heartbeat watchdog.
package mthw_pkg;

  localparam int unsigned MAX_TASKS_DEF = 8;

  localparam logic [1:0] MODE_REGISTER  = 2'd0;
  localparam logic [1:0] MODE_HEARTBEAT = 2'd1;
  localparam logic [1:0] MODE_TICK      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic reg_we;
    logic ctr_we;
    logic clr_all;
  } tbl_ctl_t;

  typedef struct packed {
    logic        match;
    logic        restart;
    logic        set_alive;
    logic        clr_alive;
    logic        ctr_we;
    logic [15:0] elapsed;
    logic [7:0]  retries;
  } step_t;

endpackage

[hdl/multi_task_heartbeat_watchdog.sv]
// Top level of the multi-task heartbeat watchdog: sequencer, task marks and result register.
//
// The block keeps up to MAX_TASKS tasks, each with an id, a timeout in ticks and a
// restart limit. The kind of an item travels in tuser: register, heartbeat or tick.
// Every item produces exactly one result, held in an output register so that the next
// item can be taken while a result waits. A register item or an unused kind passes
// straight from acceptance to the done state. A heartbeat or tick item walks the task
// table one task per cycle through the shared step unit and the single read port of
// the task memories, and stops at a matching or failing task or after the last one.
// The block is not ready while a walk is in progress. No clearing pass is needed after
// reset.
module multi_task_heartbeat_watchdog #(
  parameter int unsigned MAX_TASKS = mthw_pkg::MAX_TASKS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // task_id[31:0], timeout_ticks[47:32], restart_limit[55:48]
  input  logic [55:0] s_axis_tdata_i,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // accepted[0], restart_all[1], failing_task[4:2], tasks_held[8:5], zero[15:9]
  output logic [15:0] m_axis_tdata_o
);

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  mthw_pkg::state_e     state_q, state_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [MAX_TASKS-1:0] alive_q, alive_d;
  logic [1:0]           mode_q, mode_d;
  logic [31:0]          id_q, id_d;
  logic                 res_acc_q, res_acc_d;
  logic                 res_rst_q, res_rst_d;
  logic [IDX_W-1:0]     res_fail_q, res_fail_d;
  logic                 out_vld_q, out_vld_d;
  logic [15:0]          out_data_q, out_data_d;

  logic                 in_acc;
  logic                 out_free;
  logic                 full;
  logic                 reg_ok;
  logic                 last;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W+2:0]     fail_ext;
  logic [CNT_W+3:0]     held_ext;
  mthw_pkg::tbl_ctl_t   tbl_ctl;
  mthw_pkg::step_t      step;

  logic [31:0] rd_id;
  logic [15:0] rd_tmo;
  logic [7:0]  rd_lim;
  logic [15:0] rd_elapsed;
  logic [7:0]  rd_retries;
  logic        rd_vld;

  assign s_axis_tready_o = (state_q == mthw_pkg::ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign full            = (cnt_q == CNT_W'(MAX_TASKS));
  assign reg_ok          = (s_axis_tuser_i == mthw_pkg::MODE_REGISTER) && !full;
  assign last            = (CNT_W'(idx_q) == CNT_W'(cnt_q - 1'b1));
  assign fail_ext        = (IDX_W + 3)'(res_fail_q);
  assign held_ext        = (CNT_W + 4)'(cnt_q);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  mthw_table #(
    .MAX_TASKS(MAX_TASKS)
  ) u_table (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (tbl_ctl),
    .reg_addr_i    (cnt_q[IDX_W-1:0]),
    .reg_id_i      (s_axis_tdata_i[31:0]),
    .reg_tmo_i     (s_axis_tdata_i[47:32]),
    .reg_lim_i     (s_axis_tdata_i[55:48]),
    .ctr_addr_i    (idx_q),
    .ctr_elapsed_i (step.elapsed),
    .ctr_retries_i (step.retries),
    .rd_addr_i     (rd_addr),
    .rd_id_o       (rd_id),
    .rd_tmo_o      (rd_tmo),
    .rd_lim_o      (rd_lim),
    .rd_elapsed_o  (rd_elapsed),
    .rd_retries_o  (rd_retries),
    .rd_vld_o      (rd_vld)
  );

  mthw_step u_step (
    .mode_i       (mode_q),
    .task_id_i    (id_q),
    .rd_id_i      (rd_id),
    .rd_tmo_i     (rd_tmo),
    .rd_lim_i     (rd_lim),
    .rd_elapsed_i (rd_elapsed),
    .rd_retries_i (rd_retries),
    .rd_vld_i     (rd_vld),
    .alive_i      (alive_q[idx_q]),
    .step_o       (step)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mthw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if ((s_axis_tuser_i == mthw_pkg::MODE_HEARTBEAT ||
               s_axis_tuser_i == mthw_pkg::MODE_TICK) && cnt_q != '0) begin
            state_d = mthw_pkg::ST_WALK;
          end else begin
            state_d = mthw_pkg::ST_DONE;
          end
        end
      end
      mthw_pkg::ST_WALK: begin
        if (step.match || step.restart || last) begin
          state_d = mthw_pkg::ST_DONE;
        end
      end
      mthw_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = mthw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mthw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    tbl_ctl = '0;
    rd_addr = '0;
    unique case (state_q)
      mthw_pkg::ST_IDLE: begin
        tbl_ctl.reg_we = in_acc && reg_ok;
      end
      mthw_pkg::ST_WALK: begin
        rd_addr         = IDX_W'(idx_q + 1'b1);
        tbl_ctl.ctr_we  = step.ctr_we;
        tbl_ctl.clr_all = step.restart;
      end
      mthw_pkg::ST_DONE: begin
        tbl_ctl = '0;
      end
      default: begin
        tbl_ctl = '0;
      end
    endcase
  end

  always_comb begin
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    alive_d    = alive_q;
    mode_d     = mode_q;
    id_d       = id_q;
    res_acc_d  = res_acc_q;
    res_rst_d  = res_rst_q;
    res_fail_d = res_fail_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_data_d = out_data_q;
    unique case (state_q)
      mthw_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_d     = s_axis_tuser_i;
          id_d       = s_axis_tdata_i[31:0];
          idx_d      = '0;
          res_acc_d  = reg_ok;
          res_rst_d  = 1'b0;
          res_fail_d = '0;
          if (reg_ok) begin
            cnt_d                     = CNT_W'(cnt_q + 1'b1);
            alive_d[cnt_q[IDX_W-1:0]] = 1'b0;
          end
        end
      end
      mthw_pkg::ST_WALK: begin
        idx_d = IDX_W'(idx_q + 1'b1);
        if (step.set_alive) begin
          alive_d[idx_q] = 1'b1;
          res_acc_d      = 1'b1;
        end
        if (step.clr_alive) begin
          alive_d[idx_q] = 1'b0;
        end
        if (step.restart) begin
          alive_d    = '0;
          res_rst_d  = 1'b1;
          res_fail_d = idx_q;
        end
      end
      mthw_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_data_d = {7'd0, held_ext[3:0], fail_ext[2:0], res_rst_q, res_acc_q};
        end
      end
      default: begin
        out_vld_d = out_vld_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mthw_pkg::ST_IDLE;
      idx_q     <= '0;
      cnt_q     <= '0;
      alive_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      cnt_q     <= cnt_d;
      alive_q   <= alive_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    id_q       <= id_d;
    res_acc_q  <= res_acc_d;
    res_rst_q  <= res_rst_d;
    res_fail_q <= res_fail_d;
    out_data_q <= out_data_d;
  end

`ifndef SYNTH
  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_TASKS))
    else $error("task count exceeds the table depth");

  a_restart_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mthw_pkg::ST_WALK && step.restart) |-> (mode_q == mthw_pkg::MODE_TICK))
    else $error("restart raised outside a tick walk");

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mthw_pkg::ST_WALK && step.restart) |=>
      (alive_q == '0 && state_q == mthw_pkg::ST_DONE && res_rst_q))
    else $error("restart did not clear the marks and end the walk");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == mthw_pkg::ST_DONE))
    else $error("result presented without a finished item");
`endif

endmodule

[hdl/mthw_table.sv]
// Task tables and per-task counter memory with a single registered read port.
module mthw_table #(
  parameter int unsigned MAX_TASKS = mthw_pkg::MAX_TASKS_DEF,
  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mthw_pkg::tbl_ctl_t   ctl_i,
  input  logic [IDX_W-1:0]     reg_addr_i,
  input  logic [31:0]          reg_id_i,
  input  logic [15:0]          reg_tmo_i,
  input  logic [7:0]           reg_lim_i,
  input  logic [IDX_W-1:0]     ctr_addr_i,
  input  logic [15:0]          ctr_elapsed_i,
  input  logic [7:0]           ctr_retries_i,
  input  logic [IDX_W-1:0]     rd_addr_i,
  output logic [31:0]          rd_id_o,
  output logic [15:0]          rd_tmo_o,
  output logic [7:0]           rd_lim_o,
  output logic [15:0]          rd_elapsed_o,
  output logic [7:0]           rd_retries_o,
  output logic                 rd_vld_o
);

  logic [31:0]          id_mem  [MAX_TASKS];
  logic [23:0]          cfg_mem [MAX_TASKS];
  logic [23:0]          ctr_mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] vld_q;
  logic [MAX_TASKS-1:0] vld_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.reg_we) begin
      id_mem[reg_addr_i]  <= reg_id_i;
      cfg_mem[reg_addr_i] <= {reg_lim_i, reg_tmo_i};
    end
    if (ctl_i.ctr_we) begin
      ctr_mem[ctr_addr_i] <= {ctr_retries_i, ctr_elapsed_i};
    end
    rd_id_o                      <= id_mem[rd_addr_i];
    {rd_lim_o, rd_tmo_o}         <= cfg_mem[rd_addr_i];
    {rd_retries_o, rd_elapsed_o} <= ctr_mem[rd_addr_i];
  end

  always_comb begin
    vld_d = vld_q;
    if (ctl_i.clr_all) begin
      vld_d = '0;
    end else begin
      if (ctl_i.ctr_we) begin
        vld_d[ctr_addr_i] = 1'b1;
      end
      if (ctl_i.reg_we) begin
        vld_d[reg_addr_i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_o <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      rd_vld_o <= vld_q[rd_addr_i];
    end
  end

endmodule

[hdl/mthw_step.sv]
// Shared evaluation unit that visits one task of the table per cycle.
module mthw_step (
  input  logic [1:0]      mode_i,
  input  logic [31:0]     task_id_i,
  input  logic [31:0]     rd_id_i,
  input  logic [15:0]     rd_tmo_i,
  input  logic [7:0]      rd_lim_i,
  input  logic [15:0]     rd_elapsed_i,
  input  logic [7:0]      rd_retries_i,
  input  logic            rd_vld_i,
  input  logic            alive_i,
  output mthw_pkg::step_t step_o
);

  logic [15:0] elapsed;
  logic [7:0]  retries;
  logic [16:0] cnt_inc;
  logic [8:0]  rt_inc;

  assign elapsed = rd_vld_i ? rd_elapsed_i : 16'd0;
  assign retries = rd_vld_i ? rd_retries_i : 8'd0;
  assign cnt_inc = {1'b0, elapsed} + 17'd1;
  assign rt_inc  = {1'b0, retries} + 9'd1;

  always_comb begin
    step_o = '0;
    case (mode_i)
      mthw_pkg::MODE_HEARTBEAT: begin
        step_o.match     = (rd_id_i == task_id_i);
        step_o.set_alive = (rd_id_i == task_id_i);
      end
      mthw_pkg::MODE_TICK: begin
        if (alive_i) begin
          step_o.clr_alive = 1'b1;
          step_o.ctr_we    = 1'b1;
        end else if (cnt_inc >= {1'b0, rd_tmo_i}) begin
          if (rt_inc >= {1'b0, rd_lim_i}) begin
            step_o.restart = 1'b1;
          end else begin
            step_o.ctr_we  = 1'b1;
            step_o.retries = rt_inc[8] ? 8'hFF : rt_inc[7:0];
          end
        end else begin
          step_o.ctr_we  = 1'b1;
          step_o.elapsed = cnt_inc[15:0];
          step_o.retries = retries;
        end
      end
      default: begin
        step_o = '0;
      end
    endcase
  end

endmodule

[sim/tb_multi_task_heartbeat_watchdog.sv]
// Testbench of the multi-task heartbeat watchdog: directed and random items checked by a predictor.
`timescale 1ns / 100ps

module tb_multi_task_heartbeat_watchdog;

  localparam int unsigned TASKS = mthw_pkg::MAX_TASKS_DEF;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * (TASKS + 2);

  typedef struct packed {
    logic [6:0] pad;
    logic [3:0] tasks_held;
    logic [2:0] failing_task;
    logic       restart_all;
    logic       accepted;
  } wd_result_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] task_id;
    logic [15:0] timeout_ticks;
    logic [7:0]  restart_limit;
    bit          fixed;
    wd_result_t  outcome;
  } wd_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = mthw_pkg::MODE_REGISTER;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  // Predicted state of the task table.
  int unsigned tasks_registered = 0;
  logic [31:0] task_ids      [TASKS];
  logic [15:0] task_timeouts [TASKS];
  logic [7:0]  task_limits   [TASKS];
  bit          task_alive    [TASKS];
  logic [15:0] task_elapsed  [TASKS];
  logic [7:0]  task_retries  [TASKS];

  wd_result_t  pending_results[$];
  wd_item_t    directed_items[$];
  wd_item_t    offered;
  wd_result_t  predicted;
  wd_result_t  observed;
  bit          calm = 1'b0;
  int unsigned errors = 0;
  int unsigned quiet_cycles = 0;

  multi_task_heartbeat_watchdog #(
    .MAX_TASKS(TASKS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic wd_result_t watchdog_step(input logic [1:0] mode, input logic [31:0] id,
                                               input logic [15:0] tmo, input logic [7:0] lim);
    wd_result_t  r;
    logic [16:0] cnt;
    logic [8:0]  tries;
    bit          walking;
    r = '0;
    walking = 1'b1;
    case (mode)
      mthw_pkg::MODE_REGISTER: begin
        if (tasks_registered < TASKS) begin
          task_ids[tasks_registered] = id;
          task_timeouts[tasks_registered] = tmo;
          task_limits[tasks_registered] = lim;
          task_alive[tasks_registered] = 1'b0;
          task_elapsed[tasks_registered] = '0;
          task_retries[tasks_registered] = '0;
          tasks_registered++;
          r.accepted = 1'b1;
        end
      end
      mthw_pkg::MODE_HEARTBEAT: begin
        for (int k = 0; k < tasks_registered && !r.accepted; k++) begin
          if (task_ids[k] == id) begin
            task_alive[k] = 1'b1;
            r.accepted = 1'b1;
          end
        end
      end
      mthw_pkg::MODE_TICK: begin
        for (int k = 0; k < tasks_registered && walking; k++) begin
          if (task_alive[k]) begin
            task_alive[k] = 1'b0;
            task_elapsed[k] = '0;
            task_retries[k] = '0;
          end else begin
            cnt = {1'b0, task_elapsed[k]} + 17'd1;
            if (cnt >= {1'b0, task_timeouts[k]}) begin
              tries = {1'b0, task_retries[k]} + 9'd1;
              task_elapsed[k] = '0;
              if (tries >= {1'b0, task_limits[k]}) begin
                r.restart_all = 1'b1;
                r.failing_task = 3'(k);
                walking = 1'b0;
                for (int j = 0; j < tasks_registered; j++) begin
                  task_alive[j] = 1'b0;
                  task_elapsed[j] = '0;
                  task_retries[j] = '0;
                end
              end else begin
                task_retries[k] = (tries > 9'd255) ? 8'hFF : tries[7:0];
              end
            end else begin
              task_elapsed[k] = cnt[15:0];
            end
          end
        end
      end
      default: ;
    endcase
    r.tasks_held = tasks_registered[3:0];
    return r;
  endfunction

  function automatic wd_item_t make_item(input logic [1:0] mode, input logic [31:0] id,
                                         input logic [15:0] tmo, input logic [7:0] lim);
    wd_item_t it;
    it.mode = mode;
    it.task_id = id;
    it.timeout_ticks = tmo;
    it.restart_limit = lim;
    it.fixed = 1'b0;
    it.outcome = '0;
    return it;
  endfunction

  task automatic add_fixed(input logic [1:0] mode, input logic [31:0] id, input logic [15:0] tmo,
                           input logic [7:0] lim, input logic acc, input logic rst,
                           input logic [2:0] fail, input logic [3:0] held);
    wd_item_t it;
    it = make_item(mode, id, tmo, lim);
    it.fixed = 1'b1;
    it.outcome = '{pad: '0, tasks_held: held, failing_task: fail, restart_all: rst,
                   accepted: acc};
    directed_items.push_back(it);
  endtask

  task automatic send_item(input wd_item_t it);
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    offered = it;
    s_axis_tdata_i = {it.restart_limit, it.timeout_ticks, it.task_id};
    s_axis_tuser_i = it.mode;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
    if (exp != act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      errors++;
    end
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 6);
  end

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predicted = watchdog_step(s_axis_tuser_i, s_axis_tdata_i[31:0], s_axis_tdata_i[47:32],
                                s_axis_tdata_i[55:48]);
      pending_results.push_back(offered.fixed ? offered.outcome : predicted);
    end
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      observed = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        $error("result %0h arrived with no item outstanding", m_axis_tdata_o);
        errors++;
      end else begin
        predicted = pending_results.pop_front();
        check_field("accepted", predicted.accepted, observed.accepted);
        check_field("restart_all", predicted.restart_all, observed.restart_all);
        check_field("failing_task", predicted.failing_task, observed.failing_task);
        check_field("tasks_held", predicted.tasks_held, observed.tasks_held);
        check_field("pad", predicted.pad, observed.pad);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned random_count;
    bit          drained;
    random_count = 0;
    drained = 1'b0;

    add_fixed(mthw_pkg::MODE_TICK, 32'h0, 16'h0, 8'h0, 1'b0, 1'b0, 3'd0, 4'd0);
    add_fixed(mthw_pkg::MODE_HEARTBEAT, 32'h0, 16'h0, 8'h0, 1'b0, 1'b0, 3'd0, 4'd0);
    add_fixed(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 3'd0, 4'd0);
    add_fixed(mthw_pkg::MODE_REGISTER, 32'h0, 16'h0, 8'h0, 1'b1, 1'b0, 3'd0, 4'd1);
    // With no timeout and no limit, the first missed tick restarts everything.
    add_fixed(mthw_pkg::MODE_TICK, 32'h0, 16'h0, 8'h0, 1'b0, 1'b1, 3'd0, 4'd1);
    add_fixed(mthw_pkg::MODE_HEARTBEAT, 32'h0, 16'h0, 8'h0, 1'b1, 1'b0, 3'd0, 4'd1);
    directed_items.push_back(make_item(mthw_pkg::MODE_TICK, 32'h0, 16'h0, 8'h0));
    directed_items.push_back(make_item(mthw_pkg::MODE_HEARTBEAT, 32'h1, 16'h0, 8'h0));
    add_fixed(mthw_pkg::MODE_REGISTER, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 3'd0, 4'd2);
    directed_items.push_back(make_item(mthw_pkg::MODE_REGISTER, 32'h1234_5678, 16'd1, 8'd0));
    // A second task with an id already in use is never reached by a heartbeat.
    directed_items.push_back(make_item(mthw_pkg::MODE_REGISTER, 32'h0, 16'd2, 8'd3));
    directed_items.push_back(make_item(mthw_pkg::MODE_REGISTER, 32'hA5A5_A5A5, 16'd0, 8'd2));
    directed_items.push_back(make_item(mthw_pkg::MODE_REGISTER, 32'h5A5A_5A5A, 16'd4, 8'd1));
    directed_items.push_back(make_item(mthw_pkg::MODE_REGISTER, 32'h8000_0000, 16'd2, 8'd2));
    add_fixed(mthw_pkg::MODE_REGISTER, 32'h7FFF_FFFF, 16'd1, 8'd4, 1'b1, 1'b0, 3'd0, 4'd8);
    add_fixed(mthw_pkg::MODE_REGISTER, 32'h1, 16'd5, 8'd5, 1'b0, 1'b0, 3'd0, 4'd8);
    directed_items.push_back(make_item(mthw_pkg::MODE_HEARTBEAT, 32'h0, 16'h0, 8'h0));
    directed_items.push_back(make_item(mthw_pkg::MODE_HEARTBEAT, 32'hFFFF_FFFF, 16'h0, 8'h0));
    directed_items.push_back(make_item(mthw_pkg::MODE_HEARTBEAT, 32'h1234_5678, 16'h0, 8'h0));
    directed_items.push_back(make_item(mthw_pkg::MODE_TICK, 32'h0, 16'h0, 8'h0));
    directed_items.push_back(make_item(mthw_pkg::MODE_TICK, 32'h0, 16'h0, 8'h0));
    directed_items.push_back(make_item(mthw_pkg::MODE_HEARTBEAT, 32'hA5A5_A5A5, 16'h0, 8'h0));
    directed_items.push_back(make_item(mthw_pkg::MODE_TICK, 32'h0, 16'h0, 8'h0));
    add_fixed(MODE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b0, 1'b0, 3'd0, 4'd8);
    directed_items.push_back(make_item(mthw_pkg::MODE_HEARTBEAT, 32'hDEAD_BEEF, 16'h0, 8'h0));

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_items[i]) send_item(directed_items[i]);

    // Rounds of heartbeats closed by a tick, with some noise mixed in.
    while (random_count < RANDOM_ITEMS) begin
      calm = (random_count >= 150 && random_count < 300);
      if (!drained && random_count >= 400) begin
        s_axis_tvalid_i = 1'b0;
        while (pending_results.size() != 0) @(negedge clk_i);
        drained = 1'b1;
      end
      for (int k = 0; k < tasks_registered; k++) begin
        if ($urandom_range(99) < 70) begin
          send_item(make_item(mthw_pkg::MODE_HEARTBEAT, task_ids[k], 16'($urandom),
                              8'($urandom)));
          random_count++;
        end
      end
      if ($urandom_range(99) < 25) begin
        case ($urandom_range(3))
          0: send_item(make_item(MODE_UNUSED, $urandom, 16'($urandom), 8'($urandom)));
          1: begin
            send_item(make_item(mthw_pkg::MODE_REGISTER, $urandom, 16'($urandom),
                                8'($urandom)));
            random_count++;
          end
          2: begin
            send_item(make_item(mthw_pkg::MODE_HEARTBEAT, $urandom, 16'($urandom),
                                8'($urandom)));
            random_count++;
          end
          default: begin
            send_item(make_item(mthw_pkg::MODE_TICK, $urandom, 16'($urandom), 8'($urandom)));
            random_count++;
          end
        endcase
      end
      send_item(make_item(mthw_pkg::MODE_TICK, $urandom, 16'($urandom), 8'($urandom)));
      random_count++;
    end

    s_axis_tvalid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
hdl/mthw_pkg.sv
hdl/mthw_table.sv
hdl/mthw_step.sv
hdl/multi_task_heartbeat_watchdog.sv
sim/tb_multi_task_heartbeat_watchdog.sv
